>>> rtl/core/ffa_pkg.sv
// shared types and codes of the first-fit heap allocator
package ffa_pkg;

    localparam int unsigned OFF_W = 16;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] pay;
    } t_seg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DECODE,
        S_ACHK,
        S_SHWR,
        S_GDIV,
        S_BLKWR,
        S_FCHK,
        S_FSCK,
        S_MERGE,
        S_FINS,
        S_FFIN,
        S_RESULT
    } t_state;

endpackage

>>> rtl/core/ffa_ifs.sv
// request and response channel interfaces of the allocator
interface ffa_req_if;
    logic                     valid;
    logic                     ready;
    ffa_pkg::t_op             op;
    logic [ffa_pkg::OFF_W-1:0] request_bytes;
    logic [ffa_pkg::OFF_W-1:0] release_offset;

    modport source (output valid, output op, output request_bytes, output release_offset,
                    input ready);
    modport sink   (input valid, input op, input request_bytes, input release_offset,
                    output ready);
endinterface

interface ffa_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [ffa_pkg::OFF_W-1:0] granted_offset;
    ffa_pkg::t_status         status;

    modport source (output valid, output granted_offset, output status, input ready);
    modport sink   (input valid, input granted_offset, input status, output ready);
endinterface

>>> rtl/core/ffa_div.sv
// divider by the alignment constant using a reciprocal multiplication
module ffa_div #(
    parameter int unsigned ALIGN_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [16:0]                     i_dividend,
    output logic                            o_done,
    output logic [16:0]                     o_quot,
    output logic [$clog2(ALIGN_BYTES)-1:0]  o_rem
);
    localparam int unsigned QW  = $clog2(ALIGN_BYTES);
    localparam int unsigned SH  = 17 + QW;
    localparam logic [17:0] MUL = 18'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1)
                                      / 64'(ALIGN_BYTES));

    logic          r_go;
    logic          r_done;
    logic [16:0]   r_dvd;
    logic [34:0]   r_prod;
    logic [16:0]   r_quot;
    logic [QW-1:0] r_rem;
    logic [16:0]   w_quot;
    logic [16:0]   w_back;

    assign w_quot = 17'(r_prod >> SH);
    assign w_back = w_quot * 17'(ALIGN_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_go   <= i_start;
            r_done <= r_go;
        end
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_prod <= {18'd0, i_dividend} * {17'd0, MUL};
        end
        if (r_go) begin
            r_quot <= w_quot;
            r_rem  <= QW'(r_dvd - w_back);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

>>> rtl/core/first_fit_heap_allocator_core.sv
// first-fit heap allocator with coalescing of free segments
// Requests arrive on i_req (op, request_bytes, release_offset); one response per
// request leaves on o_rsp (granted_offset, status). A transfer happens when valid
// and ready are both high. i_req.ready is high only while no request is in work.
// Each request first runs a divide by the alignment (reciprocal multiply),
// then scans the free segment table one entry per cycle and, when an entry is
// removed or inserted, moves the following entries one per cycle.
// The response sits in an output register; if the receiver stalls, a finished
// request waits for the register to drain before the next request is taken.
// After reset a clearing pass over all HEAP_BYTES / ALIGN_BYTES slots wipes the
// in-use flags and sets up one free segment spanning the heap; no request is
// taken during it.
module first_fit_heap_allocator_core #(
    parameter int unsigned HEAP_BYTES        = 65536,
    parameter int unsigned ALIGN_BYTES       = 8,
    parameter int unsigned HEADER_BYTES      = 24,
    parameter int unsigned MAX_FREE_SEGMENTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffa_req_if.sink    i_req,
    ffa_rsp_if.source  o_rsp
);
    localparam int unsigned HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
                                    * ALIGN_BYTES;
    localparam int unsigned HUSED = (HEAP_BYTES / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int unsigned SLOTS = HEAP_BYTES / ALIGN_BYTES;
    localparam int unsigned SW    = $clog2(MAX_FREE_SEGMENTS);
    localparam int unsigned CW    = $clog2(MAX_FREE_SEGMENTS + 1);
    localparam int unsigned BW    = $clog2(SLOTS);
    localparam int unsigned QW    = $clog2(ALIGN_BYTES);
    localparam logic [16:0] HDR17 = 17'(HDR);

    ffa_pkg::t_state  r_state, n_state;
    ffa_pkg::t_op     r_op, n_op;
    ffa_pkg::t_status r_status, n_status;
    ffa_pkg::t_seg    r_prev, n_prev, r_next, n_next, r_newseg, n_newseg;
    logic [15:0]      r_bytes, n_bytes, r_off, n_off, r_grant, n_grant, r_len, n_len;
    logic [16:0]      r_need, n_need;
    logic [CW-1:0]    r_count, n_count, r_k, n_k, r_pos, n_pos;
    logic [BW-1:0]    r_idx, n_idx, r_clr, n_clr;
    logic             r_rm, n_rm, r_has_prev, n_has_prev, r_has_next, n_has_next;
    logic             r_o_valid, n_o_valid;
    logic [15:0]      r_o_grant, n_o_grant;
    ffa_pkg::t_status r_o_status, n_o_status;

    ffa_pkg::t_seg    r_seg_mem [MAX_FREE_SEGMENTS];
    ffa_pkg::t_seg    r_seg_rd, seg_wd;
    logic             seg_we, seg_re;
    logic [SW-1:0]    seg_wa, seg_ra;
    logic [15:0]      r_len_mem [SLOTS];
    logic [15:0]      r_len_rd;
    logic             r_use_mem [SLOTS];
    logic             r_use_rd;
    logic             blk_we, blk_re, use_we, use_wd;
    logic [BW-1:0]    blk_addr, use_addr;

    logic             div_start, d_done;
    logic [16:0]      div_in, d_quot;
    logic [QW-1:0]    d_rem;

    logic [16:0]      w_v, w_grant17;
    logic [15:0]      w_grant, w_fstart;
    logic [16:0]      w_fend;
    logic             w_fit, w_split, w_bad, w_after, w_mprev, w_mnext;
    logic             w_more, w_free_rdy;

    ffa_div #(.ALIGN_BYTES(ALIGN_BYTES)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .o_done     (d_done),
        .o_quot     (d_quot),
        .o_rem      (d_rem)
    );

    assign w_v       = {1'b0, r_bytes} + 17'(ALIGN_BYTES - 1);
    assign w_grant17 = {1'b0, r_seg_rd.start} + HDR17;
    assign w_grant   = w_grant17[15:0];
    assign w_fit     = {1'b0, r_seg_rd.pay} >= r_need;
    assign w_split   = {1'b0, r_seg_rd.pay} > (r_need + HDR17);
    assign w_bad     = (d_rem != '0) || ({1'b0, r_off} < HDR17) || (d_quot >= 17'(SLOTS));
    assign w_fstart  = r_off - HDR17[15:0];
    assign w_fend    = {1'b0, r_off} + {1'b0, r_len};
    assign w_after   = r_seg_rd.start > w_fstart;
    assign w_mprev   = r_has_prev &&
                       (({1'b0, r_prev.start} + HDR17 + {1'b0, r_prev.pay}) == {1'b0, w_fstart});
    assign w_mnext   = r_has_next && ({1'b0, r_next.start} == w_fend);
    assign w_more    = r_rm ? ((r_k + CW'(2)) < r_count) : (r_k > (r_pos + CW'(1)));
    assign w_free_rdy = !r_o_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffa_pkg::S_CLEAR:  if (r_clr == BW'(SLOTS - 1)) n_state = ffa_pkg::S_IDLE;
            ffa_pkg::S_IDLE:   if (i_req.valid) n_state = ffa_pkg::S_DIV;
            ffa_pkg::S_DIV:    if (d_done) n_state = ffa_pkg::S_DECODE;
            ffa_pkg::S_DECODE: begin
                if (r_op == ffa_pkg::OP_ALLOC) begin
                    n_state = (r_bytes == '0 || r_count == '0) ? ffa_pkg::S_RESULT
                                                              : ffa_pkg::S_ACHK;
                end else begin
                    n_state = w_bad ? ffa_pkg::S_RESULT : ffa_pkg::S_FCHK;
                end
            end
            ffa_pkg::S_ACHK: begin
                if (w_fit) begin
                    n_state = (!w_split && (r_k + CW'(1)) < r_count) ? ffa_pkg::S_SHWR
                                                                     : ffa_pkg::S_GDIV;
                end else if ((r_k + CW'(1)) == r_count) begin
                    n_state = ffa_pkg::S_RESULT;
                end
            end
            ffa_pkg::S_SHWR: begin
                if (!w_more) begin
                    if (!r_rm) n_state = ffa_pkg::S_FINS;
                    else if (r_op == ffa_pkg::OP_ALLOC) n_state = ffa_pkg::S_GDIV;
                    else n_state = ffa_pkg::S_FFIN;
                end
            end
            ffa_pkg::S_GDIV:  if (d_done) n_state = ffa_pkg::S_BLKWR;
            ffa_pkg::S_BLKWR: n_state = ffa_pkg::S_RESULT;
            ffa_pkg::S_FCHK: begin
                if (!r_use_rd) n_state = ffa_pkg::S_RESULT;
                else n_state = (r_count == '0) ? ffa_pkg::S_MERGE : ffa_pkg::S_FSCK;
            end
            ffa_pkg::S_FSCK: begin
                if (w_after || (r_k + CW'(1)) == r_count) n_state = ffa_pkg::S_MERGE;
            end
            ffa_pkg::S_MERGE: begin
                priority if (w_mprev && w_mnext) begin
                    n_state = ((r_pos + CW'(1)) < r_count) ? ffa_pkg::S_SHWR : ffa_pkg::S_FFIN;
                end else if (w_mprev || w_mnext) begin
                    n_state = ffa_pkg::S_FFIN;
                end else if (r_count >= CW'(MAX_FREE_SEGMENTS)) begin
                    n_state = ffa_pkg::S_RESULT;
                end else begin
                    n_state = (r_pos == r_count) ? ffa_pkg::S_FINS : ffa_pkg::S_SHWR;
                end
            end
            ffa_pkg::S_FINS:   n_state = ffa_pkg::S_FFIN;
            ffa_pkg::S_FFIN:   n_state = ffa_pkg::S_RESULT;
            ffa_pkg::S_RESULT: if (w_free_rdy) n_state = ffa_pkg::S_IDLE;
            default:           n_state = ffa_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        n_op = r_op;           n_status = r_status;   n_prev = r_prev;
        n_next = r_next;       n_newseg = r_newseg;   n_bytes = r_bytes;
        n_off = r_off;         n_grant = r_grant;     n_len = r_len;
        n_need = r_need;       n_count = r_count;     n_k = r_k;
        n_pos = r_pos;         n_idx = r_idx;         n_clr = r_clr;
        n_rm = r_rm;           n_has_prev = r_has_prev; n_has_next = r_has_next;
        n_o_valid = r_o_valid && !o_rsp.ready;
        n_o_grant = r_o_grant; n_o_status = r_o_status;
        seg_we = 1'b0; seg_wa = '0; seg_wd = '0; seg_re = 1'b0; seg_ra = '0;
        blk_we = 1'b0; blk_re = 1'b0; blk_addr = d_quot[BW-1:0];
        use_we = 1'b0; use_wd = 1'b0; use_addr = d_quot[BW-1:0];
        div_start = 1'b0; div_in = '0;
        unique case (r_state)
            ffa_pkg::S_CLEAR: begin
                use_we   = 1'b1;
                use_addr = r_clr;
                n_clr    = r_clr + BW'(1);
                if (r_clr == '0) begin
                    seg_we = 1'b1;
                    seg_wd = '{start: '0, pay: 16'(HUSED - HDR)};
                end
            end
            ffa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.op;
                    n_bytes   = i_req.request_bytes;
                    n_off     = i_req.release_offset;
                    n_grant   = '0;
                    div_start = 1'b1;
                    div_in    = (i_req.op == ffa_pkg::OP_FREE) ? {1'b0, i_req.release_offset}
                              : ({1'b0, i_req.request_bytes} + 17'(ALIGN_BYTES - 1));
                end
            end
            ffa_pkg::S_DIV: ;
            ffa_pkg::S_DECODE: begin
                if (r_op == ffa_pkg::OP_ALLOC) begin
                    if (r_bytes == '0) n_status = ffa_pkg::ST_INVALID;
                    else if (r_count == '0) n_status = ffa_pkg::ST_NOFIT;
                    else begin
                        n_need = w_v - 17'(d_rem);
                        n_k    = '0;
                        seg_re = 1'b1;
                    end
                end else if (w_bad) begin
                    n_status = ffa_pkg::ST_INVALID;
                end else begin
                    blk_re = 1'b1;
                    n_idx  = d_quot[BW-1:0];
                end
            end
            ffa_pkg::S_ACHK: begin
                if (w_fit) begin
                    n_grant = w_grant;
                    if (w_split) begin
                        seg_we = 1'b1;
                        seg_wa = r_k[SW-1:0];
                        seg_wd.start = 16'(w_grant17 + r_need);
                        seg_wd.pay   = 16'({1'b0, r_seg_rd.pay} - r_need - HDR17);
                        div_start = 1'b1;
                        div_in    = {1'b0, w_grant};
                    end else begin
                        n_need = {1'b0, r_seg_rd.pay};
                        if ((r_k + CW'(1)) < r_count) begin
                            n_rm   = 1'b1;
                            seg_re = 1'b1;
                            seg_ra = SW'(r_k + CW'(1));
                        end else begin
                            n_count   = r_count - CW'(1);
                            div_start = 1'b1;
                            div_in    = {1'b0, w_grant};
                        end
                    end
                end else if ((r_k + CW'(1)) == r_count) begin
                    n_status = ffa_pkg::ST_NOFIT;
                end else begin
                    n_k    = r_k + CW'(1);
                    seg_re = 1'b1;
                    seg_ra = SW'(r_k + CW'(1));
                end
            end
            ffa_pkg::S_SHWR: begin
                seg_we = 1'b1;
                seg_wa = r_k[SW-1:0];
                seg_wd = r_seg_rd;
                if (w_more) begin
                    seg_re = 1'b1;
                    if (r_rm) begin
                        n_k    = r_k + CW'(1);
                        seg_ra = SW'(r_k + CW'(2));
                    end else begin
                        n_k    = r_k - CW'(1);
                        seg_ra = SW'(r_k - CW'(2));
                    end
                end else if (r_rm) begin
                    n_count = r_count - CW'(1);
                    if (r_op == ffa_pkg::OP_ALLOC) begin
                        div_start = 1'b1;
                        div_in    = {1'b0, r_grant};
                    end
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ffa_pkg::S_GDIV: ;
            ffa_pkg::S_BLKWR: begin
                blk_we   = 1'b1;
                use_we   = 1'b1;
                use_wd   = 1'b1;
                n_status = ffa_pkg::ST_DONE;
            end
            ffa_pkg::S_FCHK: begin
                if (r_use_rd) begin
                    n_len      = r_len_rd;
                    n_k        = '0;
                    n_has_prev = 1'b0;
                    if (r_count == '0) begin
                        n_pos      = '0;
                        n_has_next = 1'b0;
                    end else begin
                        seg_re = 1'b1;
                    end
                end else begin
                    n_status = ffa_pkg::ST_INVALID;
                end
            end
            ffa_pkg::S_FSCK: begin
                if (w_after) begin
                    n_pos      = r_k;
                    n_next     = r_seg_rd;
                    n_has_next = 1'b1;
                end else begin
                    n_prev     = r_seg_rd;
                    n_has_prev = 1'b1;
                    if ((r_k + CW'(1)) == r_count) begin
                        n_pos      = r_count;
                        n_has_next = 1'b0;
                    end else begin
                        n_k    = r_k + CW'(1);
                        seg_re = 1'b1;
                        seg_ra = SW'(r_k + CW'(1));
                    end
                end
            end
            ffa_pkg::S_MERGE: begin
                priority if (w_mprev && w_mnext) begin
                    seg_we = 1'b1;
                    seg_wa = SW'(r_pos - CW'(1));
                    seg_wd.start = r_prev.start;
                    seg_wd.pay   = r_prev.pay + HDR17[15:0] + r_len + HDR17[15:0] + r_next.pay;
                    if ((r_pos + CW'(1)) < r_count) begin
                        n_k    = r_pos;
                        n_rm   = 1'b1;
                        seg_re = 1'b1;
                        seg_ra = SW'(r_pos + CW'(1));
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end else if (w_mprev) begin
                    seg_we = 1'b1;
                    seg_wa = SW'(r_pos - CW'(1));
                    seg_wd.start = r_prev.start;
                    seg_wd.pay   = r_prev.pay + HDR17[15:0] + r_len;
                end else if (w_mnext) begin
                    seg_we = 1'b1;
                    seg_wa = r_pos[SW-1:0];
                    seg_wd.start = w_fstart;
                    seg_wd.pay   = r_next.pay + r_len + HDR17[15:0];
                end else if (r_count >= CW'(MAX_FREE_SEGMENTS)) begin
                    n_status = ffa_pkg::ST_FULL;
                end else begin
                    n_newseg = '{start: w_fstart, pay: r_len};
                    if (r_pos == r_count) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_k    = r_count;
                        n_rm   = 1'b0;
                        seg_re = 1'b1;
                        seg_ra = SW'(r_count - CW'(1));
                    end
                end
            end
            ffa_pkg::S_FINS: begin
                seg_we = 1'b1;
                seg_wa = r_pos[SW-1:0];
                seg_wd = r_newseg;
            end
            ffa_pkg::S_FFIN: begin
                use_we   = 1'b1;
                use_addr = r_idx;
                n_status = ffa_pkg::ST_DONE;
            end
            ffa_pkg::S_RESULT: begin
                if (w_free_rdy) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_grant  = (r_status == ffa_pkg::ST_DONE) ? r_grant : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (seg_we) r_seg_mem[seg_wa] <= seg_wd;
        if (seg_re) r_seg_rd <= r_seg_mem[seg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) r_len_mem[blk_addr] <= r_need[15:0];
        if (blk_re) r_len_rd <= r_len_mem[blk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (use_we) r_use_mem[use_addr] <= use_wd;
        if (blk_re) r_use_rd <= r_use_mem[use_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffa_pkg::S_CLEAR;
            r_count   <= CW'(1);
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
        r_op <= n_op;           r_status <= n_status;     r_prev <= n_prev;
        r_next <= n_next;       r_newseg <= n_newseg;     r_bytes <= n_bytes;
        r_off <= n_off;         r_grant <= n_grant;       r_len <= n_len;
        r_need <= n_need;       r_k <= n_k;               r_pos <= n_pos;
        r_idx <= n_idx;         r_rm <= n_rm;             r_has_prev <= n_has_prev;
        r_has_next <= n_has_next;
        r_o_grant <= n_o_grant; r_o_status <= n_o_status;
    end

    assign i_req.ready          = (r_state == ffa_pkg::S_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.granted_offset = r_o_grant;
    assign o_rsp.status         = r_o_status;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FREE_SEGMENTS))
        else $error("segment count beyond table depth");

    a_no_grant_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_o_status != ffa_pkg::ST_DONE) |-> r_o_grant == '0)
        else $error("offset given with a failed request");

    a_seg_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seg_we && seg_re |-> seg_wa != seg_ra)
        else $error("segment table read and write collide");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_IDLE) |=> (r_count == $past(r_count)))
        else $error("segment count moved while idle");
`endif
endmodule
